>>> rtl/srrw_pkg.sv
package srrw_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned WS_W    = 6;
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned CFG_W   = 16;

    localparam logic CFG_WINDOW_SIZE   = 1'b0;
    localparam logic CFG_TOTAL_PACKETS = 1'b1;

    localparam logic [WS_W-1:0] WINDOW_SIZE_RST   = 6'd10;
    localparam logic [ID_W-1:0] TOTAL_PACKETS_RST = 16'd1;

    typedef struct packed {
        logic [ID_W-1:0] packet_id;
        logic            crc_good;
    } t_in;

    typedef struct packed {
        logic              ack_positive;
        logic [ID_W-1:0]   ack_id;
        logic              stored;
        logic [SLOT_W-1:0] slot_index;
        logic              window_complete;
        logic [ID_W-1:0]   complete_base;
        logic [WS_W-1:0]   complete_length;
        logic              transfer_done;
    } t_out;

    typedef struct packed {
        logic             we;
        logic             idx;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

endpackage

>>> rtl/srrw_core.sv
module srrw_core
    import srrw_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_take,
    input  t_in     i_item,
    output t_out    o_result
);

    localparam int unsigned CAP   = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
    localparam int unsigned BIT_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam logic [WS_W-1:0] CAP_V = WS_W'(CAP);

    logic [WS_W-1:0] r_ws, n_ws;
    logic [ID_W-1:0] r_total, n_total;
    logic [ID_W-1:0] r_base, n_base;
    logic [ID_W-1:0] r_left, n_left;
    logic [WS_W-1:0] r_length, n_length;
    logic [CAP-1:0]  r_bits, n_bits;

    logic [ID_W:0]   diff;
    logic            in_window;
    logic            slot_free;
    logic            store;
    logic [CAP-1:0]  set_bits;
    logic [CAP-1:0]  mask;
    logic            complete;
    logic            active;
    logic [WS_W-1:0] w_eff;
    logic [ID_W-1:0] left_after;
    logic [ID_W-1:0] restart_total;

    function automatic logic [WS_W-1:0] eff_window(input logic [WS_W-1:0] ws);
        logic [WS_W-1:0] w;
        w = ws;
        if (w == '0) begin
            w = WS_W'(1);
        end
        if (w > CAP_V) begin
            w = CAP_V;
        end
        return w;
    endfunction

    function automatic logic [WS_W-1:0] len_of(input logic [WS_W-1:0] w,
                                               input logic [ID_W-1:0] left);
        logic [WS_W-1:0] r;
        r = w;
        if ({{(ID_W-WS_W){1'b0}}, w} > left) begin
            r = left[WS_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        for (int j = 0; j < CAP; j++) begin
            mask[j] = (j < int'(r_length));
        end
    end

    assign active    = (r_left != '0);
    assign diff      = {1'b0, i_item.packet_id} - {1'b0, r_base};
    assign in_window = !diff[ID_W] && (diff[ID_W-1:0] < {{(ID_W-WS_W){1'b0}}, r_length});
    assign slot_free = !r_bits[diff[BIT_W-1:0]];
    assign store     = active && i_item.crc_good && in_window && slot_free;

    always_comb begin
        set_bits = r_bits;
        if (store) begin
            set_bits[diff[BIT_W-1:0]] = 1'b1;
        end
    end

    assign complete   = active && (set_bits == mask);
    assign w_eff      = eff_window(r_ws);
    assign left_after = r_left - {{(ID_W-WS_W){1'b0}}, r_length};

    assign restart_total = (i_cfg.idx == CFG_TOTAL_PACKETS) ? i_cfg.data : r_total;

    always_comb begin
        n_ws     = r_ws;
        n_total  = r_total;
        n_base   = r_base;
        n_left   = r_left;
        n_length = r_length;
        n_bits   = r_bits;
        if (i_cfg.we) begin
            n_ws     = (i_cfg.idx == CFG_WINDOW_SIZE) ? i_cfg.data[WS_W-1:0] : r_ws;
            n_total  = restart_total;
            n_base   = '0;
            n_left   = restart_total;
            n_length = len_of(eff_window(n_ws), restart_total);
            n_bits   = '0;
        end else if (i_take) begin
            if (complete) begin
                n_base   = r_base + {{(ID_W-WS_W){1'b0}}, r_length};
                n_left   = left_after;
                n_length = len_of(w_eff, left_after);
                n_bits   = '0;
            end else begin
                n_bits   = set_bits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws     <= WINDOW_SIZE_RST;
            r_total  <= TOTAL_PACKETS_RST;
            r_base   <= '0;
            r_left   <= TOTAL_PACKETS_RST;
            r_length <= len_of(eff_window(WINDOW_SIZE_RST), TOTAL_PACKETS_RST);
            r_bits   <= '0;
        end else begin
            r_ws     <= n_ws;
            r_total  <= n_total;
            r_base   <= n_base;
            r_left   <= n_left;
            r_length <= n_length;
            r_bits   <= n_bits;
        end
    end

    always_comb begin
        o_result.ack_positive    = i_item.crc_good;
        o_result.ack_id          = i_item.packet_id;
        o_result.stored          = store;
        o_result.slot_index      = store ? diff[SLOT_W-1:0] : '0;
        o_result.window_complete = complete;
        o_result.complete_base   = complete ? r_base : '0;
        o_result.complete_length = complete ? r_length : '0;
        o_result.transfer_done   = complete ? (left_after == '0) : !active;
    end

    // The received bitmap never holds a bit at or beyond the window length.
    a_bits_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits & ~mask) == '0)
        else $error("received bitmap outside window");

    // An open transfer always has a non-empty window no larger than the cap.
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> (r_length != '0 && r_length <= CAP_V))
        else $error("window length out of range");

    // Base plus remaining packets always equals the total.
    a_base_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base + r_left) == r_total)
        else $error("base and remaining count disagree");

    // A completed window moves the base forward by the reported length.
    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && complete && !i_cfg.we) |=>
            r_base == $past(r_base) + {{(ID_W-WS_W){1'b0}}, $past(r_length)})
        else $error("base did not advance by window length");

endmodule

>>> rtl/selective_repeat_receive_window_top.sv
// Selective-repeat receive window tracker.
// Input channel: i_valid, i_in (packet id and CRC verdict), o_stall.
// Output channel: o_valid, o_out (acknowledgement, slot and window report), i_stall.
// A request is taken at a rising edge where valid is high and stall is low.
// Every input request yields exactly one output request, registered, so the
// result appears in the cycle after acceptance. One request is accepted every
// cycle while o_stall is low; the window state updates in the same cycle the
// request is taken. When the output register is full and i_stall is high,
// o_stall rises and no new request is taken until the held result is delivered.
// Configuration: i_cfg_we writes i_cfg_data into the register picked by
// i_cfg_idx (0 window size, 1 total packets); any write restarts the transfer.
// Write only while no request is in flight.
// Synchronous reset restores window size 10 and total packets 1, clears the
// bitmap, sets the base to zero and empties the output register.
module selective_repeat_receive_window_top
    import srrw_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in              i_in,
    output logic             o_stall,
    output logic             o_valid,
    output t_out             o_out,
    input  logic             i_stall,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic    r_valid, n_valid;
    t_out    r_out;
    t_out    result;
    t_cfg_wr cfg;
    logic    take;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    srrw_core #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_take  (take),
        .i_item  (i_in),
        .o_result(result)
    );

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

>>> bench/ack_window_checker.sv
module ack_window_checker
    import srrw_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in              i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out             i_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 100;

    logic [WS_W-1:0] win_size_q;
    logic [ID_W-1:0] total_q;
    logic [ID_W-1:0] base_q;
    logic [WS_W-1:0] len_q;
    logic [31:0]     seen_map;

    t_out ack_fifo[$];

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                     $realtime, field, got, want);
        end
        o_fail_count++;
    endtask

    function automatic void reload_len();
        int unsigned cap;
        int unsigned eff;
        int unsigned left;
        cap = (MAX_WINDOW < 32) ? MAX_WINDOW : 32;
        if (cap < 1) cap = 1;
        eff = 32'(win_size_q);
        if (eff < 1) eff = 1;
        if (eff > cap) eff = cap;
        left = (base_q < total_q) ? 32'(total_q - base_q) : 0;
        len_q = WS_W'((eff < left) ? eff : left);
    endfunction

    function automatic void restart_transfer();
        base_q   = '0;
        seen_map = '0;
        reload_len();
    endfunction

    function automatic t_out next_ack(input t_in req);
        t_out        r;
        int unsigned s;
        logic [31:0] mask;
        r = '0;
        r.ack_positive = req.crc_good;
        r.ack_id       = req.packet_id;
        if (base_q < total_q) begin
            if (req.crc_good && req.packet_id >= base_q
                    && (req.packet_id - base_q) < ID_W'(len_q)) begin
                s = 32'(req.packet_id - base_q);
                if (!seen_map[s]) begin
                    seen_map[s]  = 1'b1;
                    r.stored     = 1'b1;
                    r.slot_index = s[SLOT_W-1:0];
                end
            end
            mask = (len_q >= 32) ? 32'hFFFF_FFFF : ((32'd1 << len_q) - 32'd1);
            if ((seen_map & mask) == mask) begin
                r.window_complete = 1'b1;
                r.complete_base   = base_q;
                r.complete_length = len_q;
                base_q            = base_q + ID_W'(len_q);
                seen_map          = '0;
                reload_len();
            end
        end
        r.transfer_done = (base_q >= total_q);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            win_size_q   = WINDOW_SIZE_RST;
            total_q      = TOTAL_PACKETS_RST;
            o_fail_count = 0;
            restart_transfer();
            ack_fifo.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WINDOW_SIZE) begin
                    win_size_q = i_cfg_data[WS_W-1:0];
                end else begin
                    total_q = i_cfg_data[ID_W-1:0];
                end
                restart_transfer();
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (ack_fifo.size() == 0) begin
                    report_mismatch("unexpected result, ack_id", 32'(got.ack_id), 32'd0);
                end else begin
                    want = ack_fifo.pop_front();
                    if (got.ack_positive !== want.ack_positive)
                        report_mismatch("ack_positive", 32'(got.ack_positive),
                                        32'(want.ack_positive));
                    if (got.ack_id !== want.ack_id)
                        report_mismatch("ack_id", 32'(got.ack_id), 32'(want.ack_id));
                    if (got.stored !== want.stored)
                        report_mismatch("stored", 32'(got.stored), 32'(want.stored));
                    if (got.slot_index !== want.slot_index)
                        report_mismatch("slot_index", 32'(got.slot_index),
                                        32'(want.slot_index));
                    if (got.window_complete !== want.window_complete)
                        report_mismatch("window_complete", 32'(got.window_complete),
                                        32'(want.window_complete));
                    if (got.complete_base !== want.complete_base)
                        report_mismatch("complete_base", 32'(got.complete_base),
                                        32'(want.complete_base));
                    if (got.complete_length !== want.complete_length)
                        report_mismatch("complete_length", 32'(got.complete_length),
                                        32'(want.complete_length));
                    if (got.transfer_done !== want.transfer_done)
                        report_mismatch("transfer_done", 32'(got.transfer_done),
                                        32'(want.transfer_done));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                ack_fifo.push_back(next_ack(i_in_data));
            end
        end
        o_pending = ack_fifo.size();
    end

endmodule

>>> bench/tb.sv
module tb;
    import srrw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_WINDOW  = 32;
    localparam int          ITEMS       = 950;
    localparam int          CALM_TAIL   = 100;
    localparam int          HOLD_CYCLES = 100;
    localparam int          QUIET_LIMIT = 1000;

    typedef enum int {
        NZ_BAD_CRC,
        NZ_DUPLICATE,
        NZ_OUTSIDE,
        NZ_ANY
    } t_noise;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    t_in              i_in;
    logic             o_stall;
    logic             o_valid;
    t_out             o_out;
    logic             i_stall;
    logic             i_cfg_we;
    logic             i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int sent        = 0;
    int quiet_cycles = 0;
    bit idle_en     = 1'b1;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    selective_repeat_receive_window_top #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in       (i_in),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_out      (o_out),
        .i_stall    (i_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ack_window_checker #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver either holds off for a long stretch on request or stalls in short bursts.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall   = 1'b0;
                hold_done = 1'b1;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_packet(input logic [ID_W-1:0] id, input logic good);
        @(negedge i_clk);
        if (sent >= ITEMS - CALM_TAIL) idle_en = 1'b0;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_valid           = 1'b1;
        i_in.packet_id    = id;
        i_in.crc_good     = good;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic wait_all_acked();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] ws_data,
                              input logic [CFG_W-1:0] total_data);
        wait_all_acked();
        repeat (3) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = CFG_WINDOW_SIZE;
        i_cfg_data = ws_data;
        @(negedge i_clk);
        i_cfg_idx  = CFG_TOTAL_PACKETS;
        i_cfg_data = total_data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // Sends whole windows in shuffled order, with bad, duplicate and stray requests mixed in.
    task automatic run_transfer(input logic [CFG_W-1:0] ws_data,
                                input logic [ID_W-1:0] total, input int max_windows,
                                input bit force_pressure);
        logic [ID_W-1:0] order[32];
        logic [ID_W-1:0] tmp;
        logic [ID_W-1:0] base;
        int              eff;
        int              len;
        int              windows;
        int              j;
        t_noise          kind;
        set_config(ws_data, total);
        eff = ws_data[WS_W-1:0];
        if (eff < 1) eff = 1;
        if (eff > 32) eff = 32;
        base    = '0;
        windows = 0;
        while (base < total && windows < max_windows && sent < ITEMS) begin
            len = (eff < total - base) ? eff : total - base;
            for (int i = 0; i < len; i++) order[i] = ID_W'(base + i);
            for (int i = len - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            if (force_pressure && windows == 0) begin
                hold_req = 1'b1;
            end else if ((force_pressure && windows == 1) || $urandom_range(0, 9) == 0) begin
                wait_all_acked();
            end
            for (int i = 0; i < len; i++) begin
                while ($urandom_range(0, 4) == 0) begin
                    kind = t_noise'($urandom_range(0, 3));
                    unique case (kind)
                        NZ_BAD_CRC: begin
                            send_packet(ID_W'(base + $urandom_range(0, len - 1)), 1'b0);
                        end
                        NZ_DUPLICATE: begin
                            if (i > 0) send_packet(order[$urandom_range(0, i - 1)], 1'b1);
                            else send_packet(ID_W'($urandom_range(0, 65535)), 1'b1);
                        end
                        NZ_OUTSIDE: begin
                            send_packet(ID_W'(base + len + $urandom_range(0, 40)), 1'b1);
                        end
                        default: begin
                            send_packet(ID_W'($urandom_range(0, 65535)),
                                        1'($urandom_range(0, 1)));
                        end
                    endcase
                end
                send_packet(order[i], 1'b1);
            end
            base = ID_W'(base + len);
            windows++;
        end
        if (base >= total) begin
            send_packet(ID_W'($urandom_range(0, 65535)), 1'b1);
            send_packet(base - ID_W'(1), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] ws_data;
        logic [ID_W-1:0]  total;
        int               eff;
        int               pick;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_WINDOW_SIZE;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: a window of one packet, then acknowledgements after the transfer ends.
        send_packet(16'd0, 1'b0);
        send_packet(16'hFFFF, 1'b1);
        send_packet(16'd0, 1'b1);
        send_packet(16'd0, 1'b1);

        // A window size of zero behaves as one.
        set_config(16'd0, 16'd3);
        send_packet(16'd1, 1'b1);
        send_packet(16'd0, 1'b1);
        send_packet(16'd1, 1'b0);
        send_packet(16'd1, 1'b1);
        send_packet(16'd2, 1'b1);

        // An oversized window saturates to the largest slot count.
        set_config(16'hFFFF, 16'hFFFF);
        send_packet(16'd31, 1'b1);
        send_packet(16'd31, 1'b1);
        send_packet(16'd32, 1'b1);
        send_packet(16'h8000, 1'b1);

        // A transfer of zero packets is finished from the start.
        set_config(16'd32, 16'd0);
        send_packet(16'd0, 1'b1);
        send_packet(16'hFFFF, 1'b0);

        set_config(16'd1, 16'hFFFF);
        send_packet(16'd0, 1'b1);

        run_transfer(16'd8, 16'd40, 5, 1'b1);

        while (sent < ITEMS) begin
            pick = $urandom_range(0, 9);
            unique case (pick)
                0: ws_data = 16'd0;
                1: ws_data = {10'($urandom_range(0, 1023)), 6'($urandom_range(33, 63))};
                2: ws_data = 16'd32;
                3: ws_data = 16'd1;
                default: ws_data = CFG_W'($urandom_range(2, 31));
            endcase
            eff = ws_data[WS_W-1:0];
            if (eff < 1) eff = 1;
            if (eff > 32) eff = 32;
            pick = $urandom_range(0, 9);
            unique case (pick)
                0: total = 16'd0;
                1: total = 16'hFFFF;
                2: total = ID_W'($urandom_range(1, 65535));
                default: total = ID_W'($urandom_range(1, 4 * eff + 3));
            endcase
            run_transfer(ws_data, total, 4, 1'b0);
        end

        wait_all_acked();
        repeat (5) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/srrw_pkg.sv
rtl/srrw_core.sv
rtl/selective_repeat_receive_window_top.sv
bench/ack_window_checker.sv
bench/tb.sv
